@@ design/cfr_pkg.sv @@
// ----------------------------------------------------------------------------
// CRC-checked frame receiver package
// Shared types, field kind codes, register indexes and the CRC-16 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

    // CRC-16/CCITT-FALSE: polynomial 0x1021, MSB first, initial value 0xFFFF.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    // Number of CRC bytes that close a frame.
    localparam logic [1:0] CRC_BYTES = 2'd2;

    // Field kind codes reported with every word.
    localparam logic [2:0] KIND_DISCARD = 3'd0;
    localparam logic [2:0] KIND_START   = 3'd1;
    localparam logic [2:0] KIND_ID      = 3'd2;
    localparam logic [2:0] KIND_CMD     = 3'd3;
    localparam logic [2:0] KIND_LEN     = 3'd4;
    localparam logic [2:0] KIND_PAYLOAD = 3'd5;
    localparam logic [2:0] KIND_CRC     = 3'd6;

    // Configuration register indexes.
    localparam logic REG_START_VALUE = 1'b0;
    localparam logic REG_VEHICLE_ID  = 1'b1;

    // Parser phase, one-hot.
    typedef enum logic [5:0] {
        PH_WAIT    = 6'b000001,
        PH_ID      = 6'b000010,
        PH_CMD     = 6'b000100,
        PH_LEN     = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_CRC     = 6'b100000
    } cfr_phase_t;

    // One result word.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] field_kind;
        logic [8:0] byte_index;
        logic       frame_abort;
        logic       frame_end;
        logic       frame_good;
    } cfr_result_t;

    // Feeds one byte into the running CRC, eight shift steps.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ design/cfr_in_stage.sv @@
// ----------------------------------------------------------------------------
// CRC-checked frame receiver input stage
// Registers one received word and holds it until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_in_stage (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
    input  wire logic       consume,
    output logic            in_valid,
    output logic [7:0]      in_byte
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    // A new word may enter when the stage is empty or its word leaves now.
    assign s_tready = !valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

`default_nettype wire

@@ design/cfr_frame_fsm.sv @@
// ----------------------------------------------------------------------------
// CRC-checked frame receiver frame parser
// Tracks the frame phase and running CRC and classifies each word.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_frame_fsm (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               advance,
    input  wire logic [7:0]         in_byte,
    input  wire logic [7:0]         start_value,
    input  wire logic [7:0]         vehicle_id,
    output cfr_pkg::cfr_result_t    result
);

    import cfr_pkg::*;

    cfr_phase_t  phase_reg, phase_next;
    logic [7:0]  payload_left_reg, payload_left_next;
    logic [1:0]  crc_left_reg, crc_left_next;
    logic [15:0] crc_reg, crc_next;
    logic [8:0]  count_reg, count_next;

    logic [15:0] crc_fed;
    logic [15:0] crc_first;
    logic [8:0]  count_inc;

    assign crc_fed   = crc_feed(crc_reg, in_byte);
    assign crc_first = crc_feed(CRC_INIT, in_byte);
    assign count_inc = count_reg + 9'd1;

    always_comb begin
        phase_next        = phase_reg;
        payload_left_next = payload_left_reg;
        crc_left_next     = crc_left_reg;
        crc_next          = crc_reg;
        count_next        = count_reg;

        result.out_byte    = in_byte;
        result.field_kind  = KIND_DISCARD;
        result.byte_index  = 9'd0;
        result.frame_abort = 1'b0;
        result.frame_end   = 1'b0;
        result.frame_good  = 1'b0;

        case (phase_reg)
            PH_ID: begin
                result.field_kind = KIND_ID;
                result.byte_index = 9'd1;
                if (in_byte == vehicle_id) begin
                    crc_next   = crc_fed;
                    count_next = 9'd2;
                    phase_next = PH_CMD;
                end else begin
                    // The mismatching byte is not tried as a new start byte.
                    result.frame_abort = 1'b1;
                    phase_next         = PH_WAIT;
                end
            end
            PH_CMD: begin
                result.field_kind = KIND_CMD;
                result.byte_index = count_reg;
                crc_next          = crc_fed;
                count_next        = count_inc;
                phase_next        = PH_LEN;
            end
            PH_LEN: begin
                result.field_kind = KIND_LEN;
                result.byte_index = count_reg;
                crc_next          = crc_fed;
                count_next        = count_inc;
                payload_left_next = in_byte;
                phase_next        = (in_byte != 8'd0) ? PH_PAYLOAD : PH_CRC;
            end
            PH_PAYLOAD: begin
                result.field_kind = KIND_PAYLOAD;
                result.byte_index = count_reg;
                crc_next          = crc_fed;
                count_next        = count_inc;
                if (payload_left_reg <= 8'd1) begin
                    payload_left_next = 8'd0;
                    phase_next        = PH_CRC;
                end else begin
                    payload_left_next = payload_left_reg - 8'd1;
                end
            end
            PH_CRC: begin
                result.field_kind = KIND_CRC;
                result.byte_index = count_reg;
                crc_next          = crc_fed;
                count_next        = count_inc;
                if (crc_left_reg <= 2'd1) begin
                    // Last CRC byte: a zero residue means the frame is intact.
                    crc_left_next     = 2'd0;
                    result.frame_end  = 1'b1;
                    result.frame_good = (crc_fed == 16'h0000);
                    phase_next        = PH_WAIT;
                end else begin
                    crc_left_next = crc_left_reg - 2'd1;
                end
            end
            default: begin
                phase_next = PH_WAIT;
                if (in_byte == start_value) begin
                    result.field_kind = KIND_START;
                    crc_next          = crc_first;
                    count_next        = 9'd1;
                    payload_left_next = 8'd0;
                    crc_left_next     = CRC_BYTES;
                    phase_next        = PH_ID;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_WAIT;
            payload_left_reg <= 8'd0;
            crc_left_reg     <= CRC_BYTES;
            crc_reg          <= CRC_INIT;
            count_reg        <= 9'd0;
        end else if (advance) begin
            phase_reg        <= phase_next;
            payload_left_reg <= payload_left_next;
            crc_left_reg     <= crc_left_next;
            crc_reg          <= crc_next;
            count_reg        <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ design/cfr_out_stage.sv @@
// ----------------------------------------------------------------------------
// CRC-checked frame receiver output stage
// Holds one result word and packs it onto the master stream.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_out_stage (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    input  wire cfr_pkg::cfr_result_t result,
    output logic                      out_ready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [23:0]               m_tdata,  // [7:0] out_byte, [16:8] byte_index
    output logic                      m_tlast,  // frame_end
    output logic [4:0]                m_tuser   // [2:0] field_kind, [3] frame_abort,
                                                // [4] frame_good
);

    import cfr_pkg::*;

    logic        valid_reg;
    cfr_result_t result_reg;

    assign out_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && out_ready) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, result_reg.byte_index, result_reg.out_byte};
    assign m_tlast  = result_reg.frame_end;
    assign m_tuser  = {result_reg.frame_good, result_reg.frame_abort, result_reg.field_kind};

endmodule

`default_nettype wire

@@ design/crc_checked_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// CRC-checked frame receiver
// Byte-serial deframer with CRC-16/CCITT-FALSE check and per-word tagging.
// ----------------------------------------------------------------------------
// The receiver takes one byte per word on the slave stream and returns one
// tagged word per byte on the master stream, so it sustains one word per
// clock cycle while m_tready is high. The input register takes the byte on
// acceptance, the parser logic tags it, and the result register takes the
// tagged word when it has room, which raises m_tvalid.
// A frame is a start byte, the vehicle id, a command byte, a length byte,
// that many payload bytes and two CRC bytes. Bytes outside a frame are echoed
// as discarded until one equals start_value. An id byte that differs from
// vehicle_id aborts the frame, and that byte is not tried as a start byte.
// The CRC (polynomial 0x1021, initial value 0xFFFF, no final XOR) covers
// every frame byte including both CRC bytes; the last CRC byte raises m_tlast
// and reports the frame good when the residue is zero. A start byte value
// seen inside a frame is taken as whatever field the frame expects there.
// Configuration is written through cfg_wr_en, cfg_addr and cfg_wdata
// (index 0 start_value, index 1 vehicle_id) while the stream is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_checked_frame_receiver (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port.
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_addr,
    input  wire logic [7:0]  cfg_wdata,
    // Received bytes.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Tagged result words.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] out_byte, [16:8] byte_index
    output logic             m_tlast,   // frame_end
    output logic [4:0]       m_tuser    // [2:0] field_kind, [3] frame_abort,
                                        // [4] frame_good
);

    import cfr_pkg::*;

    logic [7:0]  start_byte_reg;
    logic [7:0]  vehicle_id_reg;

    logic        in_valid;
    logic [7:0]  in_byte;
    logic        out_ready;
    logic        advance;
    cfr_result_t result;

    // Configuration registers. The index decodes to one of the two registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg <= 8'd0;
            vehicle_id_reg <= 8'd0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_START_VALUE: start_byte_reg <= cfg_wdata;
                REG_VEHICLE_ID:  vehicle_id_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // The parser state moves exactly when a word passes into the result register.
    assign advance = in_valid && out_ready;

    cfr_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .consume  (out_ready),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    cfr_frame_fsm u_frame_fsm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .in_byte     (in_byte),
        .start_value (start_byte_reg),
        .vehicle_id  (vehicle_id_reg),
        .result      (result)
    );

    cfr_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid),
        .result    (result),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Testbench for the CRC-checked frame receiver
// Streams framed and unframed bytes into the receiver and checks every tagged
// result word against a cycle-free predictor of the parser and its CRC-16.
// ----------------------------------------------------------------------------
module testbench;

    import cfr_pkg::*;

    // Generous ceiling on the run length, in clock cycles.
    localparam int unsigned CYCLE_LIMIT = 400000;
    // Number of register settings the run walks through.
    localparam int NUM_SETTINGS = 7;
    // Printed mismatch lines are capped so a broken design cannot flood the log.
    localparam int unsigned PRINT_CAP = 50;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr = REG_START_VALUE;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;     // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;             // [7:0] out_byte, [16:8] byte_index
    logic        m_tlast;             // frame_end
    logic [4:0]  m_tuser;             // [2:0] field_kind, [3] frame_abort,
                                      // [4] frame_good

    crc_checked_frame_receiver dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------------

    // Bytes waiting to be offered on the slave stream.
    logic [7:0]  rx_backlog[$];
    // Predicted result words, oldest first.
    cfr_result_t tagged_words_due[$];

    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned words_checked = 0;
    int unsigned good_frames = 0;
    int unsigned bad_frames = 0;
    int unsigned id_aborts = 0;

    // When set, the matching side runs without any idle cycles for a while.
    logic src_steady = 1'b0;
    logic sink_steady = 1'b0;

    // Shadow copies of the two configuration registers.
    logic [7:0] shadow_start = 8'h00;
    logic [7:0] shadow_id = 8'h00;

    // Parser state as the predictor sees it, starting from its reset values.
    cfr_phase_t rx_phase = PH_WAIT;
    logic [7:0] pay_left = 8'd0;
    logic [1:0] crc_left = CRC_BYTES;
    logic [15:0] crc_run = CRC_INIT;
    logic [8:0] frame_pos = 9'd0;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // CRC-16 update one bit at a time, MSB of the byte first.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = acc[15] ^ b[i];
            acc = {acc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return acc;
    endfunction

    // Advances the predicted parser by one accepted byte and returns the word
    // the receiver must produce for it.
    function automatic cfr_result_t parse_byte(input logic [7:0] b);
        cfr_result_t r;
        r = '0;
        r.out_byte = b;
        r.field_kind = KIND_DISCARD;
        case (rx_phase)
            PH_ID: begin
                r.field_kind = KIND_ID;
                r.byte_index = 9'd1;
                if (b == shadow_id) begin
                    crc_run = crc_step(crc_run, b);
                    frame_pos = 9'd2;
                    rx_phase = PH_CMD;
                end else begin
                    // The mismatching id ends the frame; it is never retried
                    // as a start byte.
                    r.frame_abort = 1'b1;
                    rx_phase = PH_WAIT;
                end
            end
            PH_CMD, PH_LEN, PH_PAYLOAD, PH_CRC: begin
                r.byte_index = frame_pos;
                crc_run = crc_step(crc_run, b);
                frame_pos = frame_pos + 9'd1;
                case (rx_phase)
                    PH_CMD: begin
                        r.field_kind = KIND_CMD;
                        rx_phase = PH_LEN;
                    end
                    PH_LEN: begin
                        r.field_kind = KIND_LEN;
                        pay_left = b;
                        rx_phase = (b != 8'd0) ? PH_PAYLOAD : PH_CRC;
                    end
                    PH_PAYLOAD: begin
                        r.field_kind = KIND_PAYLOAD;
                        if (pay_left <= 8'd1) begin
                            pay_left = 8'd0;
                            rx_phase = PH_CRC;
                        end else begin
                            pay_left = pay_left - 8'd1;
                        end
                    end
                    default: begin
                        r.field_kind = KIND_CRC;
                        if (crc_left <= 2'd1) begin
                            crc_left = 2'd0;
                            r.frame_end = 1'b1;
                            r.frame_good = (crc_run == 16'h0000);
                            rx_phase = PH_WAIT;
                        end else begin
                            crc_left = crc_left - 2'd1;
                        end
                    end
                endcase
            end
            default: begin
                rx_phase = PH_WAIT;
                if (b == shadow_start) begin
                    r.field_kind = KIND_START;
                    r.byte_index = 9'd0;
                    crc_run = crc_step(CRC_INIT, b);
                    frame_pos = 9'd1;
                    pay_left = 8'd0;
                    crc_left = CRC_BYTES;
                    rx_phase = PH_ID;
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Idle patterns
    // ------------------------------------------------------------------------

    // Mostly no pause, often a short one, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Payload lengths stay small in most frames so that many frames fit in
    // the run; a few reach well into the byte range.
    function automatic int payload_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(0, 6);
        else if (r < 97)
            return $urandom_range(7, 40);
        else
            return $urandom_range(41, 255);
    endfunction

    // ------------------------------------------------------------------------
    // Cycle counter: run limit and the switching of idle-free stretches.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 400 == 0) begin
            src_steady <= ($urandom_range(0, 3) == 0);
            sink_steady <= ($urandom_range(0, 3) == 0);
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words still due",
                     cycle_count, tagged_words_due.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver: offers the backlog one word at a time with random gaps. The word
    // is handed to the predictor at the edge where the receiver accepts it.
    // ------------------------------------------------------------------------
    int src_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                tagged_words_due.push_back(parse_byte(s_tdata));
            end
            // The slot is free when nothing is offered or the offer was taken.
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap = src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (rx_backlog.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= rx_backlog.pop_front();
                    src_gap = src_steady ? 0 : idle_len();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: drives random back-pressure and checks every accepted word.
    // ------------------------------------------------------------------------
    int sink_stall = 0;

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("Mismatch at cycle %0d, word %0d: %s is 0x%0h, expected 0x%0h",
                     cycle_count, words_checked, field, got, want);
    endtask

    always @(posedge aclk) begin
        cfr_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (tagged_words_due.size() == 0) begin
                    report_mismatch("unexpected word, out_byte", m_tdata[7:0], 0);
                end else begin
                    want = tagged_words_due.pop_front();
                    if (m_tdata[7:0] != want.out_byte)
                        report_mismatch("out_byte", m_tdata[7:0], want.out_byte);
                    if (m_tdata[16:8] != want.byte_index)
                        report_mismatch("byte_index", m_tdata[16:8], want.byte_index);
                    if (m_tdata[23:17] != 7'd0)
                        report_mismatch("tdata padding", m_tdata[23:17], 0);
                    if (m_tuser[2:0] != want.field_kind)
                        report_mismatch("field_kind", m_tuser[2:0], want.field_kind);
                    if (m_tuser[3] != want.frame_abort)
                        report_mismatch("frame_abort", m_tuser[3], want.frame_abort);
                    if (m_tlast != want.frame_end)
                        report_mismatch("frame_end", m_tlast, want.frame_end);
                    if (m_tuser[4] != want.frame_good)
                        report_mismatch("frame_good", m_tuser[4], want.frame_good);
                    if (want.frame_end) begin
                        if (want.frame_good)
                            good_frames++;
                        else
                            bad_frames++;
                    end
                    if (want.frame_abort)
                        id_aborts++;
                end
                words_checked++;
            end
            if (sink_stall > 0) begin
                sink_stall = sink_stall - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!sink_steady && $urandom_range(0, 3) == 0)
                    sink_stall = idle_len();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Writes one configuration register; the stream is idle whenever this runs.
    task automatic write_reg(input logic idx, input logic [7:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_START_VALUE)
            shadow_start = value;
        else
            shadow_id = value;
    endtask

    // Queues a frame for the current start and id values with a random payload
    // and a CRC that makes the residue zero. A corrupted frame gets one bit
    // flipped after the id; a nonzero keep cuts the frame after that many bytes.
    task automatic queue_frame(input logic [7:0] cmd, input int len, input bit corrupt,
                               input int keep);
        logic [7:0]  f[$];
        logic [15:0] crc;
        int          pos;
        int          n;
        f.push_back(shadow_start);
        f.push_back(shadow_id);
        f.push_back(cmd);
        f.push_back(8'(len));
        for (int k = 0; k < len; k++)
            f.push_back(8'($urandom));
        crc = CRC_INIT;
        foreach (f[k])
            crc = crc_step(crc, f[k]);
        f.push_back(crc[15:8]);
        f.push_back(crc[7:0]);
        if (corrupt) begin
            pos = $urandom_range(2, f.size() - 1);
            f[pos] = f[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        n = (keep > 0 && keep < f.size()) ? keep : f.size();
        for (int k = 0; k < n; k++)
            rx_backlog.push_back(f[k]);
    endtask

    // Waits until every queued byte has gone in and every word has come out,
    // then lets the pipeline settle before anything else happens.
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (rx_backlog.size() != 0 || s_tvalid || tagged_words_due.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        int         sel;
        int         len;
        int         budget;
        logic [7:0] b;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
            // The first setting keeps the reset values of both registers; the second
            // uses 0x7E and 0x01, the next ones cover the extremes, then random values.
            if (setting > 0) begin
                case (setting)
                    1: begin
                        write_reg(REG_START_VALUE, 8'h7E);
                        write_reg(REG_VEHICLE_ID, 8'h01);
                    end
                    2: begin
                        write_reg(REG_START_VALUE, 8'hFF);
                        write_reg(REG_VEHICLE_ID, 8'hFF);
                    end
                    3: begin
                        write_reg(REG_START_VALUE, 8'hFF);
                        write_reg(REG_VEHICLE_ID, 8'h00);
                    end
                    4: begin
                        write_reg(REG_START_VALUE, 8'h00);
                        write_reg(REG_VEHICLE_ID, 8'hFF);
                    end
                    default: begin
                        write_reg(REG_START_VALUE, 8'($urandom));
                        write_reg(REG_VEHICLE_ID, 8'($urandom));
                    end
                endcase
            end
            @(negedge aclk);

            if (setting == 0) begin
                // Bytes outside a frame come back tagged as discarded, 0xFF among them.
                rx_backlog.push_back(8'hFF);
                rx_backlog.push_back(8'hA5);
                // Zero-length frame whose command equals the start value, which
                // must not resynchronize the parser.
                queue_frame(8'h00, 0, 1'b0, 0);
                // One payload byte and a flipped bit, so the frame ends bad.
                queue_frame(8'hFF, 1, 1'b1, 0);
                // Wrong id right after the start byte aborts the frame.
                rx_backlog.push_back(shadow_start);
                rx_backlog.push_back(8'h5A);
            end else if (setting == 1) begin
                // The aborting id byte equals the start value and must not
                // open a new frame, so the next byte is discarded.
                rx_backlog.push_back(8'h7E);
                rx_backlog.push_back(8'h7E);
                rx_backlog.push_back(8'h01);
            end

            // Two settings carry one frame of the longest payload.
            if (setting == 2 || setting == NUM_SETTINGS - 1)
                queue_frame(8'($urandom), 255, 1'b0, 0);

            // Random part: mostly well-formed frames with random content, the
            // rest bad CRCs, id aborts, truncated frames and line noise.
            budget = rx_backlog.size() + 45;
            while (rx_backlog.size() < budget) begin
                sel = $urandom_range(0, 99);
                if (sel < 70) begin
                    queue_frame(8'($urandom), payload_len(), ($urandom_range(0, 4) == 0), 0);
                end else if (sel < 80) begin
                    b = 8'($urandom);
                    if (b == shadow_id)
                        b = ~b;
                    rx_backlog.push_back(shadow_start);
                    rx_backlog.push_back(b);
                end else if (sel < 90) begin
                    len = payload_len();
                    queue_frame(8'($urandom), len, 1'b0, $urandom_range(1, len + 5));
                end else begin
                    repeat ($urandom_range(1, 4))
                        rx_backlog.push_back(8'($urandom));
                end
            end

            wait_drained();
        end

        $display("Checked %0d result words over %0d register settings in %0d cycles.",
                 words_checked, NUM_SETTINGS, cycle_count);
        $display("Frames seen: %0d good, %0d with a bad CRC, %0d id aborts; %0d mismatches.",
                 good_frames, bad_frames, id_aborts, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
